FILE: rtl/kqt_pkg.sv
// ----------------------------------------------------------------------------
// kqt_pkg
// Shared types, codes and sizes for the keyed quantity table with sorted
// readout: request and result codes, controller commands and datapath status.
// ----------------------------------------------------------------------------
package kqt_pkg;

    // table size and derived widths
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 32;
    localparam int QTY_W       = 32;
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 3;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic signed [QTY_W-1:0] qty_t;

    // request kinds
    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_SEARCH = 2'd1,
        MODE_UPDATE = 2'd2,
        MODE_LIST   = 2'd3
    } mode_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_PRESENT   = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_EMPTY     = 3'd4
    } status_t;

    // source of the store write data
    typedef enum logic [1:0] {
        WR_SHIFT = 2'd0,   // move the entry read at idx up to idx + 1
        WR_NEW   = 2'd1,   // new key and quantity at idx
        WR_SUM   = 2'd2    // saturated sum into the quantity at idx
    } wr_src_t;

    // source of the result payload
    typedef enum logic [2:0] {
        OUT_ZERO = 3'd0,   // zero key and quantity
        OUT_REQ  = 3'd1,   // request key and amount
        OUT_RAM  = 3'd2,   // request key and stored quantity
        OUT_SUM  = 3'd3,   // request key and saturated sum
        OUT_LIST = 3'd4    // stored key and stored quantity
    } out_src_t;

    // controller to datapath
    typedef struct packed {
        logic     req_ready;
        logic     idx_clr;
        logic     idx_inc;
        logic     idx_dec;
        logic     idx_top;
        logic     key_we;
        logic     qty_we;
        wr_src_t  wr_src;
        logic     cnt_inc;
        logic     out_load;
        out_src_t out_src;
        status_t  out_status;
        logic     out_last;
    } kqt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic  req_valid;
        mode_t mode;
        logic  key_eq;
        logic  key_gt;
        logic  idx_zero;
        logic  idx_last;
        logic  cnt_zero;
        logic  cnt_full;
        logic  out_free;
    } kqt_sts_t;

endpackage

FILE: rtl/kqt_req_if.sv
// ----------------------------------------------------------------------------
// kqt_req_if
// Request channel: valid/ready handshake with mode, key and amount.
// ----------------------------------------------------------------------------
interface kqt_req_if;
    import kqt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [MODE_W-1:0]    mode;
    logic signed [KEY_W-1:0] part_key;
    logic signed [QTY_W-1:0] amount;

    modport source (output valid, output mode, output part_key, output amount,
                    input ready);
    modport sink   (input valid, input mode, input part_key, input amount,
                    output ready);
endinterface

FILE: rtl/kqt_rsp_if.sv
// ----------------------------------------------------------------------------
// kqt_rsp_if
// Result channel: valid/ready handshake with status, key, quantity and last.
// ----------------------------------------------------------------------------
interface kqt_rsp_if;
    import kqt_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic signed [KEY_W-1:0] out_key;
    logic signed [QTY_W-1:0] out_quantity;
    logic                    last;

    modport source (output valid, output status, output out_key,
                    output out_quantity, output last, input ready);
    modport sink   (input valid, input status, input out_key,
                    input out_quantity, input last, output ready);
endinterface

FILE: rtl/kqt_ram.sv
// ----------------------------------------------------------------------------
// kqt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module kqt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/kqt_datapath.sv
// ----------------------------------------------------------------------------
// kqt_datapath
// Request capture, entry index and count, key and quantity stores, saturating
// adder, key compares and the result register.
// ----------------------------------------------------------------------------
module kqt_datapath (
    input  logic              clk,
    input  logic              rst_n,
    kqt_req_if.sink           req,
    kqt_rsp_if.source         rsp,
    input  kqt_pkg::kqt_cmd_t cmd,
    output kqt_pkg::kqt_sts_t sts
);
    import kqt_pkg::*;

    mode_t            mode_reg;
    key_t             key_reg;
    qty_t             amt_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    status_t          out_status_reg;
    key_t             out_key_reg;
    qty_t             out_qty_reg;
    logic             out_last_reg;

    logic [KEY_W-1:0] rd_key;
    logic [QTY_W-1:0] rd_qty;
    logic [IDX_W-1:0] wr_addr;
    logic [KEY_W-1:0] wr_key;
    logic [QTY_W-1:0] wr_qty;
    logic             req_accept;
    logic             out_free;
    logic signed [QTY_W:0] sum_wide;
    qty_t             sum_sat;
    key_t             res_key;
    qty_t             res_qty;

    assign req.ready  = cmd.req_ready;
    assign req_accept = req.valid && cmd.req_ready;
    assign out_free   = !out_valid_reg || rsp.ready;

    // key and quantity stores
    kqt_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
        .clk   (clk),
        .we    (cmd.key_we),
        .waddr (wr_addr),
        .wdata (wr_key),
        .raddr (idx_reg),
        .rdata (rd_key)
    );

    kqt_ram #(.WIDTH(QTY_W), .DEPTH(TABLE_DEPTH)) u_qty_ram (
        .clk   (clk),
        .we    (cmd.qty_we),
        .waddr (wr_addr),
        .wdata (wr_qty),
        .raddr (idx_reg),
        .rdata (rd_qty)
    );

    // saturating add of the change to the stored quantity
    assign sum_wide = {rd_qty[QTY_W-1], rd_qty} + {amt_reg[QTY_W-1], amt_reg};
    always_comb
    begin
        if (sum_wide[QTY_W] != sum_wide[QTY_W-1])
        begin
            sum_sat = sum_wide[QTY_W] ? {1'b1, {(QTY_W-1){1'b0}}}
                                      : {1'b0, {(QTY_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[QTY_W-1:0];
        end
    end

    // store write address and data
    always_comb
    begin
        case (cmd.wr_src)
            WR_SHIFT:
            begin
                wr_addr = idx_reg + IDX_W'(1);
                wr_key  = rd_key;
                wr_qty  = rd_qty;
            end
            WR_NEW:
            begin
                wr_addr = idx_reg;
                wr_key  = key_reg;
                wr_qty  = amt_reg;
            end
            WR_SUM:
            begin
                wr_addr = idx_reg;
                wr_key  = rd_key;
                wr_qty  = sum_sat;
            end
            default:
            begin
                wr_addr = idx_reg;
                wr_key  = rd_key;
                wr_qty  = rd_qty;
            end
        endcase
    end

    // result payload select
    always_comb
    begin
        case (cmd.out_src)
            OUT_REQ:
            begin
                res_key = key_reg;
                res_qty = amt_reg;
            end
            OUT_RAM:
            begin
                res_key = key_reg;
                res_qty = rd_qty;
            end
            OUT_SUM:
            begin
                res_key = key_reg;
                res_qty = sum_sat;
            end
            OUT_LIST:
            begin
                res_key = rd_key;
                res_qty = rd_qty;
            end
            default:
            begin
                res_key = '0;
                res_qty = '0;
            end
        endcase
    end

    // index, count and result valid
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_top)
        begin
            idx_next = IDX_W'(cnt_reg - CNT_W'(1));
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
        else if (cmd.idx_dec)
        begin
            idx_next = idx_reg - IDX_W'(1);
        end

        cnt_next = cnt_reg + (cmd.cnt_inc ? CNT_W'(1) : CNT_W'(0));

        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request and result payload registers
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            mode_reg <= mode_t'(req.mode);
            key_reg  <= req.part_key;
            amt_reg  <= req.amount;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= cmd.out_status;
            out_key_reg    <= res_key;
            out_qty_reg    <= res_qty;
            out_last_reg   <= cmd.out_last;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.out_key      = out_key_reg;
    assign rsp.out_quantity = out_qty_reg;
    assign rsp.last         = out_last_reg;

    // status toward the controller
    assign sts.req_valid = req.valid;
    assign sts.mode      = mode_reg;
    assign sts.key_eq    = (rd_key == key_reg);
    assign sts.key_gt    = ($signed(rd_key) > key_reg);
    assign sts.idx_zero  = (idx_reg == '0);
    assign sts.idx_last  = (CNT_W'(idx_reg) == cnt_reg - CNT_W'(1));
    assign sts.cnt_zero  = (cnt_reg == '0);
    assign sts.cnt_full  = (cnt_reg == DEPTH_CNT);
    assign sts.out_free  = out_free;
endmodule

FILE: rtl/kqt_ctrl.sv
// ----------------------------------------------------------------------------
// kqt_ctrl
// Request sequencer: key scan, ordered insert shift, update write-back and
// sorted list readout, driving the datapath by commands.
// ----------------------------------------------------------------------------
module kqt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  kqt_pkg::kqt_sts_t sts,
    output kqt_pkg::kqt_cmd_t cmd
);
    import kqt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SHIFT_RD,
        S_SHIFT_CHK,
        S_INS_WR,
        S_REPLY,
        S_LIST_RD,
        S_LIST_OUT
    } state_t;

    state_t  state_reg, state_next;
    status_t reply_reg, reply_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        reply_next = reply_reg;
        cmd        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd.req_ready = 1'b1;
                if (sts.req_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                cmd.idx_clr = 1'b1;
                unique case (sts.mode) inside
                    MODE_INSERT:
                    begin
                        if (sts.cnt_full)
                        begin
                            reply_next = STAT_FULL;
                            state_next = S_REPLY;
                        end
                        else if (sts.cnt_zero)
                        begin
                            state_next = S_INS_WR;
                        end
                        else
                        begin
                            state_next = S_SCAN_RD;
                        end
                    end
                    MODE_SEARCH, MODE_UPDATE:
                    begin
                        if (sts.cnt_zero)
                        begin
                            reply_next = STAT_NOT_FOUND;
                            state_next = S_REPLY;
                        end
                        else
                        begin
                            state_next = S_SCAN_RD;
                        end
                    end
                    MODE_LIST:
                    begin
                        if (sts.cnt_zero)
                        begin
                            reply_next = STAT_EMPTY;
                            state_next = S_REPLY;
                        end
                        else
                        begin
                            state_next = S_LIST_RD;
                        end
                    end
                endcase
            end

            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end

            // compare the entry read at the index with the request key
            S_SCAN_CHK:
            begin
                if (sts.key_eq)
                begin
                    if (sts.mode == MODE_INSERT)
                    begin
                        reply_next = STAT_PRESENT;
                        state_next = S_REPLY;
                    end
                    else if (sts.out_free)
                    begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = STAT_OK;
                        cmd.out_last   = 1'b1;
                        cmd.out_src    = OUT_RAM;
                        if (sts.mode == MODE_UPDATE)
                        begin
                            cmd.qty_we  = 1'b1;
                            cmd.wr_src  = WR_SUM;
                            cmd.out_src = OUT_SUM;
                        end
                        state_next = S_IDLE;
                    end
                end
                else if (sts.idx_last)
                begin
                    if (sts.mode == MODE_INSERT)
                    begin
                        cmd.idx_top = 1'b1;
                        state_next  = S_SHIFT_RD;
                    end
                    else
                    begin
                        reply_next = STAT_NOT_FOUND;
                        state_next = S_REPLY;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end
            end

            S_SHIFT_RD:
            begin
                state_next = S_SHIFT_CHK;
            end

            // move larger keys up one slot until the insert point is found
            S_SHIFT_CHK:
            begin
                if (sts.key_gt)
                begin
                    cmd.key_we = 1'b1;
                    cmd.qty_we = 1'b1;
                    cmd.wr_src = WR_SHIFT;
                    if (sts.idx_zero)
                    begin
                        state_next = S_INS_WR;
                    end
                    else
                    begin
                        cmd.idx_dec = 1'b1;
                        state_next  = S_SHIFT_RD;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_INS_WR;
                end
            end

            // write the new entry and report it
            S_INS_WR:
            begin
                if (sts.out_free)
                begin
                    cmd.key_we     = 1'b1;
                    cmd.qty_we     = 1'b1;
                    cmd.wr_src     = WR_NEW;
                    cmd.cnt_inc    = 1'b1;
                    cmd.out_load   = 1'b1;
                    cmd.out_src    = OUT_REQ;
                    cmd.out_status = STAT_OK;
                    cmd.out_last   = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            // single refusal or empty result
            S_REPLY:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_src    = OUT_ZERO;
                    cmd.out_status = reply_reg;
                    cmd.out_last   = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_LIST_RD:
            begin
                state_next = S_LIST_OUT;
            end

            // one beat per stored entry, already in key order
            S_LIST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_src    = OUT_LIST;
                    cmd.out_status = STAT_OK;
                    cmd.out_last   = sts.idx_last;
                    if (sts.idx_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_LIST_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and reply code
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            reply_reg <= STAT_OK;
        end
        else
        begin
            state_reg <= state_next;
            reply_reg <= reply_next;
        end
    end
endmodule

FILE: rtl/keyed_quantity_table_sorted_list_top.sv
// ----------------------------------------------------------------------------
// keyed_quantity_table_sorted_list_top
// Table of up to TABLE_DEPTH unique signed keys with signed quantities:
// insert, search, saturating update and sorted list readout.
// ----------------------------------------------------------------------------
// The table is kept in ascending key order at all times, so a list request
// simply reads the stores front to back. One request is worked at a time,
// through a single read port per store with a registered read: each entry
// visited takes a read state and a check state. Search and update scan from
// the front until the key is found or the last entry is checked; insert scans
// the whole table for a duplicate and then shifts larger keys up one slot,
// from the top down, before it writes the new entry; a duplicate is refused
// where it is found; list gives one beat per stored entry. An insert into a
// full table, or a search, update or list on an empty one, is answered from
// dispatch with no scan. A result beat held by a low ready stalls the
// sequencer wherever it must load the next beat. The result register frees
// the request side: a new request is taken while the previous result beat
// still waits on ready. No clearing pass is needed after reset.
module keyed_quantity_table_sorted_list_top (
    input  logic      clk,
    input  logic      rst_n,
    kqt_req_if.sink   req,
    kqt_rsp_if.source rsp
);
    import kqt_pkg::*;

    kqt_cmd_t cmd;
    kqt_sts_t sts;

    // sequencer
    kqt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    // stores, compares and result register
    kqt_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .sts   (sts)
    );
endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keyed quantity table. A mirror of the table is
// kept in sorted order and used to predict every result beat: insert with its
// full and duplicate refusals, search, saturating update and the sorted list
// readout. Directed and random requests run with both sides stalling, then a full table and more random ones without.
// ----------------------------------------------------------------------------
module tb_top;
    import kqt_pkg::*;

    // one table entry as the bench mirrors it
    typedef struct {
        key_t key;
        qty_t qty;
    } entry_t;

    // one predicted result beat
    typedef struct {
        status_t status;
        key_t    key;
        qty_t    qty;
        logic    last;
    } result_t;

    localparam longint QTY_HI = 64'sd2147483647;
    localparam longint QTY_LO = -64'sd2147483648;

    logic clk;
    logic rst_n;

    kqt_req_if req ();
    kqt_rsp_if rsp ();

    keyed_quantity_table_sorted_list_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    entry_t      table_entries[$];
    result_t     pending_results[$];
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned mismatch_count;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    function automatic void note_failure(string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s", $time, what);
    endfunction

    function automatic int find_entry(key_t k);
        foreach (table_entries[i])
            if (table_entries[i].key == k)
                return i;
        return -1;
    endfunction

    function automatic qty_t saturate_add(qty_t base, qty_t delta);
        longint sum;
        sum = longint'(base) + longint'(delta);
        if (sum > QTY_HI)
            sum = QTY_HI;
        else if (sum < QTY_LO)
            sum = QTY_LO;
        return qty_t'(sum);
    endfunction

    function automatic void push_result(status_t s, key_t k, qty_t q, logic l);
        result_t r;
        r.status = s;
        r.key    = k;
        r.qty    = q;
        r.last   = l;
        pending_results.push_back(r);
    endfunction

    // update the mirror and queue the beats one accepted request causes
    function automatic void predict_results(mode_t m, key_t k, qty_t a);
        int     hit;
        int     pos;
        entry_t fresh;
        hit = find_entry(k);
        pos = 0;
        case (m) inside
            MODE_INSERT:
            begin
                if (table_entries.size() >= TABLE_DEPTH)
                    push_result(STAT_FULL, '0, '0, 1'b1);
                else if (hit >= 0)
                    push_result(STAT_PRESENT, '0, '0, 1'b1);
                else
                begin
                    while (pos < table_entries.size() && table_entries[pos].key < k)
                        pos++;
                    fresh.key = k;
                    fresh.qty = a;
                    table_entries.insert(pos, fresh);
                    push_result(STAT_OK, k, a, 1'b1);
                end
            end
            MODE_SEARCH, MODE_UPDATE:
            begin
                if (hit < 0)
                    push_result(STAT_NOT_FOUND, '0, '0, 1'b1);
                else
                begin
                    if (m == MODE_UPDATE)
                        table_entries[hit].qty = saturate_add(table_entries[hit].qty, a);
                    push_result(STAT_OK, k, table_entries[hit].qty, 1'b1);
                end
            end
            default:
            begin
                if (table_entries.size() == 0)
                    push_result(STAT_EMPTY, '0, '0, 1'b1);
                else
                    foreach (table_entries[i])
                        push_result(STAT_OK, table_entries[i].key, table_entries[i].qty,
                                    i == table_entries.size() - 1);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin : check_beat
        result_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_results.size() == 0)
                note_failure($sformatf("unexpected beat: status %0d key %0d qty %0d last %0b",
                                       rsp.status, rsp.out_key, rsp.out_quantity, rsp.last));
            else
            begin
                want = pending_results.pop_front();
                if (rsp.status !== want.status || rsp.out_key !== want.key ||
                    rsp.out_quantity !== want.qty || rsp.last !== want.last)
                    note_failure($sformatf(
                        "mismatch: expected status %0d key %0d qty %0d last %0b, got status %0d key %0d qty %0d last %0b",
                        want.status, want.key, want.qty, want.last,
                        rsp.status, rsp.out_key, rsp.out_quantity, rsp.last));
            end
        end
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
            rsp.ready = ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // one request beat, entered and left at a falling edge
    task automatic send_request(mode_t m, key_t k, qty_t a);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid = 1'b0;
            @(negedge clk);
        end
        req.valid    = 1'b1;
        req.mode     = m;
        req.part_key = k;
        req.amount   = a;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        predict_results(m, k, a);
        @(negedge clk);
    endtask

    // hold off the request side until every predicted beat has come back
    task automatic drain_results();
        req.valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(3))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    // mostly keys already stored, some small colliding keys, some wide ones
    function automatic key_t pick_key();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 45 && table_entries.size() != 0)
            return table_entries[$urandom_range(table_entries.size() - 1)].key;
        if (roll < 60)
            return key_t'(int'($urandom_range(16)) - 8);
        if (roll < 66)
            return key_t'(pick_extreme());
        return key_t'($urandom());
    endfunction

    function automatic qty_t pick_amount();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 25)
            return qty_t'(pick_extreme());
        if (roll < 55)
            return qty_t'(int'($urandom_range(200)) - 100);
        return qty_t'($urandom());
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // edge keys, refusals, saturation both ways, small and empty lists
    task automatic test_directed();
        send_request(MODE_LIST, key_t'($urandom()), qty_t'($urandom()));
        send_request(MODE_SEARCH, 32'sd0, 32'sd0);
        send_request(MODE_UPDATE, 32'sd5, 32'sd9);
        send_request(MODE_INSERT, 32'sh8000_0000, 32'sh7fff_ffff);
        send_request(MODE_LIST, key_t'($urandom()), qty_t'($urandom()));
        send_request(MODE_INSERT, 32'sh7fff_ffff, 32'sh8000_0000);
        send_request(MODE_INSERT, 32'sd0, 32'sd0);
        send_request(MODE_INSERT, -32'sd1, -32'sd1);
        send_request(MODE_INSERT, 32'sh7fff_ffff, 32'sd7);
        send_request(MODE_SEARCH, 32'sh8000_0000, 32'sd3);
        send_request(MODE_SEARCH, 32'sd12345, 32'sd0);
        // saturate up, then down twice, then plain sums
        send_request(MODE_UPDATE, 32'sh8000_0000, 32'sd1);
        send_request(MODE_UPDATE, 32'sh7fff_ffff, 32'sh8000_0000);
        send_request(MODE_UPDATE, 32'sh7fff_ffff, -32'sd1);
        send_request(MODE_UPDATE, 32'sd0, 32'sh7fff_ffff);
        send_request(MODE_UPDATE, 32'sd0, 32'sh8000_0000);
        send_request(MODE_UPDATE, -32'sd1, 32'sd1);
        send_request(MODE_LIST, 32'sd0, 32'sd0);
        send_request(MODE_INSERT, 32'sh5555_5555, 32'shaaaa_aaaa);
        send_request(MODE_INSERT, 32'shaaaa_aaaa, 32'sh5555_5555);
        send_request(MODE_SEARCH, 32'sh5555_5555, 32'sd0);
        send_request(MODE_LIST, key_t'($urandom()), qty_t'($urandom()));
    endtask

    task automatic test_random_requests(int unsigned count, int unsigned insert_pct);
        int unsigned roll;
        mode_t       m;
        for (int unsigned n = 0; n < count; n++)
        begin
            roll = $urandom_range(99);
            if (roll >= 92)
                m = MODE_LIST;
            else if (roll < insert_pct)
                m = MODE_INSERT;
            else if (roll[0])
                m = MODE_SEARCH;
            else
                m = MODE_UPDATE;
            send_request(m, pick_key(), pick_amount());
        end
    endtask

    // fill with fresh keys, then work a full table
    task automatic test_table_full();
        key_t k;
        while (table_entries.size() < TABLE_DEPTH)
        begin
            k = key_t'($urandom());
            if (find_entry(k) < 0)
                send_request(MODE_INSERT, k, pick_amount());
        end
        send_request(MODE_INSERT, table_entries[0].key, pick_amount());
        send_request(MODE_INSERT, key_t'($urandom()), pick_amount());
        send_request(MODE_LIST, key_t'($urandom()), qty_t'($urandom()));
        send_request(MODE_SEARCH, table_entries[TABLE_DEPTH - 1].key, pick_amount());
        send_request(MODE_UPDATE, table_entries[TABLE_DEPTH / 2].key, pick_amount());
        send_request(MODE_LIST, key_t'($urandom()), qty_t'($urandom()));
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n          = 1'b0;
        req.valid      = 1'b0;
        req.mode       = MODE_INSERT;
        req.part_key   = '0;
        req.amount     = '0;
        rsp.ready      = 1'b0;
        mismatch_count = 0;
        set_idling(29, 52);
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_requests(100, 40);
        drain_results();

        set_idling(52, 29);
        test_random_requests(90, 45);
        drain_results();

        set_idling(0, 0);
        test_table_full();
        test_random_requests(80, 30);
        drain_results();

        // allow for any stray beat after the last expected one
        repeat (300) @(posedge clk);
        if (pending_results.size() != 0)
            note_failure($sformatf("%0d expected beats never arrived", pending_results.size()));

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/kqt_pkg.sv
rtl/kqt_req_if.sv
rtl/kqt_rsp_if.sv
rtl/kqt_ram.sv
rtl/kqt_datapath.sv
rtl/kqt_ctrl.sv
rtl/keyed_quantity_table_sorted_list_top.sv
tb/tb_top.sv
